// ===== rtl/core/gmsp_pkg.sv =====
package gmsp_pkg;

	localparam int MAX_ROWS = 64;
	localparam int MAX_COLS = 64;
	localparam int CELLS    = MAX_ROWS * MAX_COLS;
	localparam int CELL_W   = $clog2(CELLS);
	localparam int CNT_W    = CELL_W + 1;
	localparam int DIM_W    = 7;
	localparam int RC_W     = 6;

	localparam logic [1:0] MV_RIGHT = 2'd0;
	localparam logic [1:0] MV_LEFT  = 2'd1;
	localparam logic [1:0] MV_DOWN  = 2'd2;
	localparam logic [1:0] MV_UP    = 2'd3;

	localparam logic FUNC_LOAD = 1'b0;
	localparam logic FUNC_READ = 1'b1;

	localparam logic [1:0] KIND_FLOOR = 2'd0;
	localparam logic [1:0] KIND_WALL  = 2'd1;
	localparam logic [1:0] KIND_START = 2'd2;
	localparam logic [1:0] KIND_GOAL  = 2'd3;

	localparam logic REG_ROWS = 1'b0;
	localparam logic REG_COLS = 1'b1;

	typedef enum logic [14:0] {
		S_IDLE = 15'b000000000000001,
		S_CLR  = 15'b000000000000010,
		S_CHK  = 15'b000000000000100,
		S_DIV  = 15'b000000000001000,
		S_INIT = 15'b000000000010000,
		S_DEQ  = 15'b000000000100000,
		S_QWT  = 15'b000000001000000,
		S_CELL = 15'b000000010000000,
		S_NRD  = 15'b000000100000000,
		S_NWT  = 15'b000001000000000,
		S_GRD  = 15'b000010000000000,
		S_GWT  = 15'b000100000000000,
		S_TRD  = 15'b001000000000000,
		S_TWT  = 15'b010000000000000,
		S_FIN  = 15'b100000000000000
	} gmsp_state_t;

endpackage

// ===== rtl/core/grid_maze_shortest_path_unit.sv =====
// Grid maze shortest path unit.
// Write grid_rows (index 0) and grid_cols (index 1) through wr_en/wr_index/wr_data
// while the unit is idle. Issue words with start while busy is low.
// A load word (func 0) stores the next cell in row-major order; a read word
// (func 1) looks up the move at step_index of the last found path.
// Every word gives one result word on result_valid in the cycle after the word
// is taken, except the load that completes the grid: that one starts the
// search and its result (search_done 1) comes when the search is over.
// Loads and reads run one per cycle while the unit is idle. The search is
// serial over the cell memories: it clears the visited marks, finds the start
// row by repeated subtraction, then takes each cell from the queue and reads
// each of its neighbors inside the grid, then traces the path back one move
// at a time. busy stays high for that whole time.
// The receiver cannot stall: every result word is shown for exactly one cycle.
// Reset puts the unit in idle, clears the counters and found/length state to zero and
// sets the grid size to 1x1; cell memories are not cleared and need a full grid load.
module grid_maze_shortest_path_unit (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        wr_en,
	input  logic                        wr_index,
	input  logic [gmsp_pkg::DIM_W-1:0]  wr_data,
	input  logic                        start,
	output logic                        busy,
	input  logic                        func,
	input  logic [1:0]                  cell_kind,
	input  logic [gmsp_pkg::CELL_W-1:0] step_index,
	output logic                        result_valid,
	output logic                        search_done,
	output logic                        found,
	output logic [gmsp_pkg::CELL_W-1:0] path_length,
	output logic [1:0]                  move_dir,
	output logic                        index_ok
);
	import gmsp_pkg::*;

	// cell memories
	logic              wall_mem [CELLS];
	logic [2:0]        vis_mem  [CELLS];   // {visited, parent move}
	logic [2*RC_W-1:0] queue_mem[CELLS];   // {row, col}
	logic [1:0]        path_mem [CELLS];

	gmsp_state_t state_q;

	logic [DIM_W-1:0]  rows_q, cols_q, rows_e, cols_e;
	logic [CNT_W-1:0]  total;
	logic [CELL_W-1:0] load_cnt_q, start_q, goal_q, len_q;
	logic              found_q;

	logic [CELL_W-1:0] clr_idx_q, rem_q, s_q, n_q, cur_q, plen_q;
	logic [RC_W-1:0]   cur_r_q, cur_c_q;
	logic [CNT_W-1:0]  head_q, tail_q;
	logic [1:0]        k_q, dir_q;
	logic [2*RC_W-1:0] nrc_q;
	logic              sfound_q;

	logic              wall_rd, result_valid_q, done_q, ok_q;
	logic [2:0]        vis_rd;
	logic [2*RC_W-1:0] queue_rd;
	logic [1:0]        path_rd;

	logic              take, take_load, take_read, last_load, read_ok;
	logic [CNT_W-1:0]  s_calc;
	logic              nb_valid;
	logic [CELL_W-1:0] nb_cell;
	logic [2*RC_W-1:0] nb_rc;
	logic [1:0]        nb_dir;
	logic [CELL_W-1:0] vis_raddr;
	logic [CELL_W-1:0] path_raddr;

	// clamp the size registers into range
	always_comb begin
		if (rows_q == '0) begin
			rows_e = DIM_W'(1);
		end else if (rows_q > DIM_W'(MAX_ROWS)) begin
			rows_e = DIM_W'(MAX_ROWS);
		end else begin
			rows_e = rows_q;
		end
		if (cols_q == '0) begin
			cols_e = DIM_W'(1);
		end else if (cols_q > DIM_W'(MAX_COLS)) begin
			cols_e = DIM_W'(MAX_COLS);
		end else begin
			cols_e = cols_q;
		end
	end

	assign total = CNT_W'(rows_e) * CNT_W'(cols_e);

	assign busy      = (state_q != S_IDLE);
	assign take      = start && !busy;
	assign take_load = take && (func == FUNC_LOAD);
	assign take_read = take && (func == FUNC_READ);
	assign last_load = ({1'b0, load_cnt_q} + CNT_W'(1)) >= total;
	assign read_ok   = found_q && (step_index < len_q);
	assign path_raddr = len_q - CELL_W'(1) - step_index;

	assign s_calc = CNT_W'(cur_r_q) * CNT_W'(cols_e) + CNT_W'(cur_c_q);

	// neighbor k of the current cell: up, down, left, right
	always_comb begin
		nb_valid = 1'b0;
		nb_cell  = s_q;
		nb_rc    = {cur_r_q, cur_c_q};
		nb_dir   = MV_UP;
		unique case (k_q)
			2'd0: begin
				nb_valid = (cur_r_q != '0);
				nb_cell  = s_q - CELL_W'(cols_e);
				nb_rc    = {cur_r_q - RC_W'(1), cur_c_q};
				nb_dir   = MV_UP;
			end
			2'd1: begin
				nb_valid = (DIM_W'(cur_r_q) + DIM_W'(1)) < rows_e;
				nb_cell  = s_q + CELL_W'(cols_e);
				nb_rc    = {cur_r_q + RC_W'(1), cur_c_q};
				nb_dir   = MV_DOWN;
			end
			2'd2: begin
				nb_valid = (cur_c_q != '0);
				nb_cell  = s_q - CELL_W'(1);
				nb_rc    = {cur_r_q, cur_c_q - RC_W'(1)};
				nb_dir   = MV_LEFT;
			end
			2'd3: begin
				nb_valid = (DIM_W'(cur_c_q) + DIM_W'(1)) < cols_e;
				nb_cell  = s_q + CELL_W'(1);
				nb_rc    = {cur_r_q, cur_c_q + RC_W'(1)};
				nb_dir   = MV_RIGHT;
			end
			default: begin
				nb_valid = 1'b0;
			end
		endcase
	end

	always_comb begin
		priority if (state_q == S_GRD) begin
			vis_raddr = goal_q;
		end else if (state_q == S_TRD) begin
			vis_raddr = cur_q;
		end else begin
			vis_raddr = nb_cell;
		end
	end

	// memories: one write and one registered read each
	always_ff @(posedge clk) begin
		if (take_load) begin
			wall_mem[load_cnt_q] <= (cell_kind == KIND_WALL);
		end
		if (state_q == S_NRD) begin
			wall_rd <= wall_mem[nb_cell];
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_CLR) begin
			vis_mem[clr_idx_q] <= 3'b000;
		end else if (state_q == S_INIT) begin
			vis_mem[start_q] <= 3'b100;
		end else if (state_q == S_NWT && !vis_rd[2] && !wall_rd) begin
			vis_mem[n_q] <= {1'b1, dir_q};
		end
		if (state_q == S_NRD || state_q == S_GRD || state_q == S_TRD) begin
			vis_rd <= vis_mem[vis_raddr];
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_INIT) begin
			queue_mem[CELL_W'(0)] <= {cur_r_q, rem_q[RC_W-1:0]};
		end else if (state_q == S_NWT && !vis_rd[2] && !wall_rd) begin
			queue_mem[tail_q[CELL_W-1:0]] <= nrc_q;
		end
		if (state_q == S_DEQ) begin
			queue_rd <= queue_mem[head_q[CELL_W-1:0]];
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_TWT) begin
			path_mem[plen_q] <= vis_rd[1:0];
		end
		if (take_read) begin
			path_rd <= path_mem[path_raddr];
		end
	end

	// sequencer and control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= S_IDLE;
			rows_q         <= DIM_W'(1);
			cols_q         <= DIM_W'(1);
			load_cnt_q     <= '0;
			start_q        <= '0;
			goal_q         <= '0;
			len_q          <= '0;
			found_q        <= 1'b0;
			result_valid_q <= 1'b0;
			done_q         <= 1'b0;
			ok_q           <= 1'b0;
			clr_idx_q      <= '0;
			rem_q          <= '0;
			cur_r_q        <= '0;
			cur_c_q        <= '0;
			s_q            <= '0;
			n_q            <= '0;
			nrc_q          <= '0;
			dir_q          <= MV_RIGHT;
			k_q            <= '0;
			head_q         <= '0;
			tail_q         <= '0;
			cur_q          <= '0;
			plen_q         <= '0;
			sfound_q       <= 1'b0;
		end else begin
			if (wr_en) begin
				unique case (wr_index)
					REG_ROWS: rows_q <= wr_data;
					REG_COLS: cols_q <= wr_data;
					default:  rows_q <= rows_q;
				endcase
			end

			result_valid_q <= take_read || (take_load && !last_load) || (state_q == S_FIN);
			done_q         <= (state_q == S_FIN);
			ok_q           <= take_read && read_ok;

			unique case (state_q)
				S_IDLE: begin
					if (take_load) begin
						// first cell of a grid drops any old start and goal
						if (cell_kind == KIND_START) begin
							start_q <= load_cnt_q;
						end else if (load_cnt_q == '0) begin
							start_q <= '0;
						end
						if (cell_kind == KIND_GOAL) begin
							goal_q <= load_cnt_q;
						end else if (load_cnt_q == '0) begin
							goal_q <= '0;
						end
						if (last_load) begin
							load_cnt_q <= '0;
							clr_idx_q  <= '0;
							state_q    <= S_CLR;
						end else begin
							load_cnt_q <= load_cnt_q + CELL_W'(1);
						end
					end
				end
				S_CLR: begin
					clr_idx_q <= clr_idx_q + CELL_W'(1);
					if ({1'b0, clr_idx_q} == total - CNT_W'(1)) begin
						state_q <= S_CHK;
					end
				end
				S_CHK: begin
					sfound_q <= 1'b0;
					plen_q   <= '0;
					if (CNT_W'(start_q) >= total || CNT_W'(goal_q) >= total) begin
						state_q <= S_FIN;
					end else begin
						rem_q   <= start_q;
						cur_r_q <= '0;
						state_q <= S_DIV;
					end
				end
				S_DIV: begin
					// split the start cell into row and column
					if (rem_q >= CELL_W'(cols_e)) begin
						rem_q   <= rem_q - CELL_W'(cols_e);
						cur_r_q <= cur_r_q + RC_W'(1);
					end else begin
						state_q <= S_INIT;
					end
				end
				S_INIT: begin
					head_q  <= '0;
					tail_q  <= CNT_W'(1);
					state_q <= S_DEQ;
				end
				S_DEQ: begin
					if (head_q == tail_q) begin
						state_q <= S_GRD;
					end else begin
						head_q  <= head_q + CNT_W'(1);
						state_q <= S_QWT;
					end
				end
				S_QWT: begin
					cur_r_q <= queue_rd[2*RC_W-1:RC_W];
					cur_c_q <= queue_rd[RC_W-1:0];
					state_q <= S_CELL;
				end
				S_CELL: begin
					s_q <= s_calc[CELL_W-1:0];
					k_q <= '0;
					if (s_calc[CELL_W-1:0] == goal_q) begin
						state_q <= S_GRD;
					end else begin
						state_q <= S_NRD;
					end
				end
				S_NRD: begin
					n_q   <= nb_cell;
					nrc_q <= nb_rc;
					dir_q <= nb_dir;
					if (nb_valid) begin
						state_q <= S_NWT;
					end else if (k_q == 2'd3) begin
						state_q <= S_DEQ;
					end else begin
						k_q <= k_q + 2'd1;
					end
				end
				S_NWT: begin
					if (!vis_rd[2] && !wall_rd) begin
						tail_q <= tail_q + CNT_W'(1);
					end
					if (k_q == 2'd3) begin
						state_q <= S_DEQ;
					end else begin
						k_q     <= k_q + 2'd1;
						state_q <= S_NRD;
					end
				end
				S_GRD: begin
					state_q <= S_GWT;
				end
				S_GWT: begin
					if (vis_rd[2]) begin
						sfound_q <= 1'b1;
						cur_q    <= goal_q;
						plen_q   <= '0;
						state_q  <= S_TRD;
					end else begin
						state_q <= S_FIN;
					end
				end
				S_TRD: begin
					if (cur_q == start_q) begin
						state_q <= S_FIN;
					end else begin
						state_q <= S_TWT;
					end
				end
				S_TWT: begin
					// step back against the move that entered this cell
					plen_q <= plen_q + CELL_W'(1);
					unique case (vis_rd[1:0])
						MV_RIGHT: cur_q <= cur_q - CELL_W'(1);
						MV_LEFT:  cur_q <= cur_q + CELL_W'(1);
						MV_DOWN:  cur_q <= cur_q - CELL_W'(cols_e);
						MV_UP:    cur_q <= cur_q + CELL_W'(cols_e);
						default:  cur_q <= cur_q;
					endcase
					state_q <= S_TRD;
				end
				S_FIN: begin
					found_q <= sfound_q;
					len_q   <= sfound_q ? plen_q : '0;
					state_q <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign result_valid = result_valid_q;
	assign search_done  = done_q;
	assign found        = found_q;
	assign path_length  = len_q;
	assign index_ok     = ok_q;
	assign move_dir     = ok_q ? path_rd : MV_RIGHT;

endmodule
